@@ rtl/hs_pkg.sv @@
// Shared definitions for the heap sorter: word width, default capacity,
// datapath operation codes and the command/status structs between
// controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

  localparam int WORD_W       = 32;
  localparam int CAPACITY_DEF = 64;

  // Datapath operations issued by the controller, one per cycle.
  localparam int OP_W = 4;
  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_IDLE         = 4'd0;
  localparam op_t OP_LOAD         = 4'd1;
  localparam op_t OP_BUILD_INIT   = 4'd2;
  localparam op_t OP_BUILD_NEXT   = 4'd3;
  localparam op_t OP_LDV          = 4'd4;
  localparam op_t OP_SIFT_DESCEND = 4'd5;
  localparam op_t OP_SIFT_STOP    = 4'd6;
  localparam op_t OP_RDL          = 4'd7;
  localparam op_t OP_CMP_MOVE     = 4'd8;
  localparam op_t OP_ROOT_RD      = 4'd9;
  localparam op_t OP_SW0          = 4'd10;
  localparam op_t OP_SW1          = 4'd11;
  localparam op_t OP_EMIT_START   = 4'd12;
  localparam op_t OP_EMIT         = 4'd13;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic left_in;   // left child of the current node lies inside the heap
    logic sink;      // larger child beats the value being sifted down
    logic hb_gt1;    // heap still holds more than one element
    logic i_zero;    // bottom-up build has visited every inner node
    logic k_last;    // emit index points at the final stored element
    logic out_free;  // output register can take a new result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/hs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first behavior on a same-address collision. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/hs_dp.sv @@
// Heap sorter datapath: element memory, counters, sift registers, comparators
// and the output register. Depends on hs_pkg and hs_ram.
`timescale 1ns / 1ps
`default_nettype none

module hs_dp #(
  parameter int CAPACITY = hs_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire hs_pkg::dp_cmd_t                   cmd,
  output      hs_pkg::dp_status_t                status,
  input  wire logic signed [hs_pkg::WORD_W-1:0]  value,
  output      logic signed [hs_pkg::WORD_W-1:0]  sorted_value,
  output      logic                              final_res,
  output      logic                              overflow,
  output      logic                              out_valid,
  input  wire logic                              out_stall
);
  import hs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = CW + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0] count;
  logic          dropped;
  logic [CW-1:0] hb;
  logic [CW-1:0] bidx;
  logic [AW-1:0] node;
  logic [AW-1:0] k;
  logic signed [WORD_W-1:0] hold;
  logic signed [WORD_W-1:0] child;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [WORD_W-1:0]        wdata;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [WORD_W-1:0]        rdata_raw;
  logic signed [WORD_W-1:0] rdata;

  logic [LW-1:0]            left_idx;
  logic [LW-1:0]            right_idx;
  logic                     right_in;
  logic                     use_right;
  logic signed [WORD_W-1:0] big_val;
  logic [AW-1:0]            big_idx;
  logic [CW-1:0]            i_dec;
  logic [CW-1:0]            hb_dec;
  logic                     has_room;

  hs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = $signed(rdata_raw);

  // Child indexes of the node being sifted; wide enough for 2*CAPACITY.
  assign left_idx  = (LW'(node) << 1) + LW'(1);
  assign right_idx = left_idx + LW'(1);
  assign right_in  = right_idx < LW'(hb);
  // In the compare step the read data is the right child, the left one sits in child.
  assign use_right = right_in && (rdata > child);
  assign big_val   = use_right ? rdata : child;
  assign big_idx   = use_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
  assign i_dec     = bidx - CW'(1);
  assign hb_dec    = hb - CW'(1);
  assign has_room  = count < CAP_C;

  always_comb begin
    status.left_in  = left_idx < LW'(hb);
    status.sink     = big_val > hold;
    status.hb_gt1   = hb > CW'(1);
    status.i_zero   = bidx == '0;
    status.k_last   = (CW'(k) + CW'(1)) == count;
    status.out_free = !out_valid || !out_stall;
  end

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = hold;
    re    = 1'b0;
    raddr = k;
    case (cmd.op)
      OP_LOAD: begin
        we    = has_room;
        waddr = count[AW-1:0];
        wdata = value;
      end
      OP_BUILD_NEXT: begin
        re    = 1'b1;
        raddr = i_dec[AW-1:0];
      end
      OP_SIFT_DESCEND: begin
        re    = 1'b1;
        raddr = left_idx[AW-1:0];
      end
      OP_SIFT_STOP: begin
        we = 1'b1;
      end
      OP_RDL: begin
        re    = 1'b1;
        raddr = right_in ? right_idx[AW-1:0] : left_idx[AW-1:0];
      end
      OP_CMP_MOVE: begin
        we    = 1'b1;
        wdata = big_val;
      end
      OP_ROOT_RD: begin
        re    = 1'b1;
        raddr = '0;
      end
      OP_SW0: begin
        re    = 1'b1;
        raddr = hb_dec[AW-1:0];
      end
      OP_SW1: begin
        we    = 1'b1;
        waddr = hb_dec[AW-1:0];
        wdata = child;
      end
      OP_EMIT_START: begin
        re    = 1'b1;
        raddr = '0;
      end
      OP_EMIT: begin
        re    = !status.k_last;
        raddr = k + AW'(1);
      end
      default: begin
        we = 1'b0;
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      hb        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (has_room) begin
            count <= count + CW'(1);
          end else begin
            dropped <= 1'b1;
          end
        end
        OP_BUILD_INIT: hb <= count;
        OP_SW1:        hb <= hb_dec;
        OP_EMIT_START: hb <= '0;
        OP_EMIT: begin
          if (status.k_last) begin
            count   <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
          hb <= hb;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_BUILD_INIT: bidx <= count >> 1;
      OP_BUILD_NEXT: begin
        bidx <= i_dec;
        node <= i_dec[AW-1:0];
      end
      OP_LDV:      hold  <= rdata;
      OP_RDL:      child <= rdata;
      OP_CMP_MOVE: node  <= big_idx;
      OP_SW0:      child <= rdata;
      OP_SW1: begin
        hold <= rdata;
        node <= '0;
      end
      OP_EMIT_START: k <= '0;
      OP_EMIT: begin
        sorted_value <= rdata;
        final_res    <= status.k_last;
        overflow     <= dropped;
        if (!status.k_last) begin
          k <= k + AW'(1);
        end
      end
      default: begin
        node <= node;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("element count exceeds capacity");

  a_swap_heap: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SW1) |-> (hb > CW'(1)))
    else $error("root swap with a heap of fewer than two elements");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> (count != '0))
    else $error("emitting from an empty batch");

endmodule

`default_nettype wire

@@ rtl/hs_ctrl.sv @@
// Heap sorter controller: load, heap build, sort-down and emit sequencing.
// Issues one datapath operation per cycle. Depends on hs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               last,
  input  wire hs_pkg::dp_status_t status,
  output      hs_pkg::dp_cmd_t    cmd
);
  import hs_pkg::*;

  localparam logic [3:0] S_LOAD       = 4'd0;
  localparam logic [3:0] S_BUILD_INIT = 4'd1;
  localparam logic [3:0] S_BUILD_NEXT = 4'd2;
  localparam logic [3:0] S_LDV        = 4'd3;
  localparam logic [3:0] S_SIFT       = 4'd4;
  localparam logic [3:0] S_RDL        = 4'd5;
  localparam logic [3:0] S_CMP        = 4'd6;
  localparam logic [3:0] S_SORT_CHECK = 4'd7;
  localparam logic [3:0] S_SW0        = 4'd8;
  localparam logic [3:0] S_SW1        = 4'd9;
  localparam logic [3:0] S_EMIT       = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       sort_phase;
  logic [3:0] ret_state;

  // A finished sift returns to the build loop or to the sort-down loop.
  assign ret_state = sort_phase ? S_SORT_CHECK : S_BUILD_NEXT;
  assign in_stall  = state != S_LOAD;

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (last) begin
            state_next = S_BUILD_INIT;
          end
        end
      end
      S_BUILD_INIT: begin
        cmd.op     = OP_BUILD_INIT;
        state_next = S_BUILD_NEXT;
      end
      S_BUILD_NEXT: begin
        if (status.i_zero) begin
          state_next = S_SORT_CHECK;
        end else begin
          cmd.op     = OP_BUILD_NEXT;
          state_next = S_LDV;
        end
      end
      S_LDV: begin
        cmd.op     = OP_LDV;
        state_next = S_SIFT;
      end
      S_SIFT: begin
        if (status.left_in) begin
          cmd.op     = OP_SIFT_DESCEND;
          state_next = S_RDL;
        end else begin
          cmd.op     = OP_SIFT_STOP;
          state_next = ret_state;
        end
      end
      S_RDL: begin
        cmd.op     = OP_RDL;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.sink) begin
          cmd.op     = OP_CMP_MOVE;
          state_next = S_SIFT;
        end else begin
          cmd.op     = OP_SIFT_STOP;
          state_next = ret_state;
        end
      end
      S_SORT_CHECK: begin
        if (status.hb_gt1) begin
          cmd.op     = OP_ROOT_RD;
          state_next = S_SW0;
        end else begin
          cmd.op     = OP_EMIT_START;
          state_next = S_EMIT;
        end
      end
      S_SW0: begin
        cmd.op     = OP_SW0;
        state_next = S_SW1;
      end
      S_SW1: begin
        cmd.op     = OP_SW1;
        state_next = S_SIFT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op = OP_EMIT;
          if (status.k_last) begin
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      sort_phase <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_BUILD_INIT) begin
        sort_phase <= 1'b0;
      end else if (state_next == S_SORT_CHECK) begin
        sort_phase <= 1'b1;
      end
    end
  end

  a_cmp_after_rdl: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ($past(state) == S_RDL))
    else $error("compare step entered without a child read");

  a_batch_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && status.out_free && status.k_last) |=> (state == S_LOAD))
    else $error("controller did not return to loading after the final result");

  a_swap_sifts: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW1) |=> (state == S_SIFT && sort_phase))
    else $error("root swap not followed by a sort-phase sift");

endmodule

`default_nettype wire

@@ rtl/heap_sorter_top.sv @@
// Heap sorter top level: batch heapsort of signed 32-bit values.
// Joins the controller (hs_ctrl) and the datapath (hs_dp); depends on hs_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall, value, last) takes one element per
//   transaction. Elements are stored in arrival order, one per cycle, until a
//   transaction with last set; that element is stored too and sorting starts.
//   Elements beyond CAPACITY are dropped and every result of that batch then
//   carries overflow = 1.
//   The output channel (out_valid, out_stall, sorted_value, final_res,
//   overflow) delivers the batch in ascending order, final_res marking the
//   last one. After the last transaction of a batch the input is stalled
//   during heap build, sort-down and emit. Each sift-down level reads the
//   left child, reads the right child, then compares and moves, against a
//   single-port-read element memory. Results leave at one per cycle while
//   the receiver does not stall; a stall simply holds the output register
//   and pauses the emit sequence. The input opens again as soon as the
//   final result is in the output register, even if it is not yet taken.
//   Synchronous reset empties the batch and clears the overflow flag; the
//   element memory itself is not cleared, since only written entries are read.
`timescale 1ns / 1ps
`default_nettype none

module heap_sorter_top #(
  parameter int CAPACITY = hs_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic signed [hs_pkg::WORD_W-1:0] value,
  input  wire logic                             last,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic signed [hs_pkg::WORD_W-1:0] sorted_value,
  output      logic                             final_res,
  output      logic                             overflow
);
  import hs_pkg::*;

  // The controller sequences; the datapath owns all storage and compares.
  dp_cmd_t    cmd;
  dp_status_t status;

  hs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .last     (last),
    .status   (status),
    .cmd      (cmd)
  );

  hs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

`default_nettype wire

@@ tb/tb_heap_sorter_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for heap_sorter_top: random and directed batches of
// signed words go in, and the ascending runs that come out are checked against
// a scoreboard holding its own heapsort. Depends on hs_pkg and heap_sorter_top.

module tb_heap_sorter_top;

  localparam int WORD_W      = hs_pkg::WORD_W;
  localparam int CAPACITY    = hs_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int MAX_REPORTS = 100;   // keeps the log short if the block is badly off
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off that backs up the block
  localparam int TAIL_CYCLES = 60;    // quiet cycles after the last result

  // One expected result transaction.
  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     final_mark;
    logic                     ovf;
  } sorted_word_t;

  // Scoreboard: mirrors the batch store, sorts it when the closing element
  // arrives and keeps the resulting run until the block delivers it.
  class sorted_run_board;
    logic signed [WORD_W-1:0] slots [CAPACITY];
    int                       loaded;
    bit                       dropped;
    sorted_word_t             pending [$];
    int                       error_count;

    function new();
      loaded      = 0;
      dropped     = 0;
      error_count = 0;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    // Sift one node down a max-heap of the given size.
    function void sink(int node, int bound);
      int                       big;
      int                       kid_l;
      int                       kid_r;
      bit                       settled;
      logic signed [WORD_W-1:0] tmp;
      settled = 0;
      while (!settled) begin
        big   = node;
        kid_l = 2 * node + 1;
        kid_r = 2 * node + 2;
        if (kid_l < bound && slots[kid_l] > slots[big]) big = kid_l;
        if (kid_r < bound && slots[kid_r] > slots[big]) big = kid_r;
        if (big == node) begin
          settled = 1;
        end else begin
          tmp         = slots[big];
          slots[big]  = slots[node];
          slots[node] = tmp;
          node        = big;
        end
      end
    endfunction

    // Heapsort the stored batch in place and queue one result per element.
    function void sort_loaded();
      int                       idx;
      int                       tail;
      logic signed [WORD_W-1:0] tmp;
      sorted_word_t             item;
      for (idx = loaded / 2 - 1; idx >= 0; idx--) sink(idx, loaded);
      for (tail = loaded - 1; tail > 0; tail--) begin
        tmp         = slots[0];
        slots[0]    = slots[tail];
        slots[tail] = tmp;
        sink(0, tail);
      end
      for (idx = 0; idx < loaded; idx++) begin
        item.word       = slots[idx];
        item.final_mark = (idx == loaded - 1);
        item.ovf        = dropped;
        pending.push_back(item);
      end
      loaded  = 0;
      dropped = 0;
    endfunction

    // Called for every accepted input transaction.
    function void note_element(logic signed [WORD_W-1:0] word, logic closes);
      if (loaded < CAPACITY) begin
        slots[loaded] = word;
        loaded++;
      end else begin
        dropped = 1;
      end
      if (closes) sort_loaded();
    endfunction

    function void report(string what, logic signed [WORD_W-1:0] want,
                         logic signed [WORD_W-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Called for every accepted output transaction.
    function void check_result(logic signed [WORD_W-1:0] word, logic final_mark, logic ovf);
      sorted_word_t want;
      if (pending.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %0d final=%0b overflow=%0b",
                   $time, word, final_mark, ovf);
        return;
      end
      want = pending.pop_front();
      if (word !== want.word) report("sorted_value", want.word, word);
      if (final_mark !== want.final_mark) report("final_res", want.final_mark, final_mark);
      if (ovf !== want.ovf) report("overflow", want.ovf, ovf);
    endfunction
  endclass

  // Every block input has a known value from time zero; reset starts high.
  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic signed [WORD_W-1:0] value     = '0;
  logic                     last      = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] sorted_value;
  logic                     final_res;
  logic                     overflow;

  sorted_run_board board = new();

  // Idle rates in percent, set by the stimulus per phase and read by both sides.
  int send_idle_pct = 6;
  int recv_idle_pct = 50;
  int elements_sent = 0;

  heap_sorter_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow)
  );

  always #10 clk = ~clk;

  // Sender side idles at random between transactions. Valid is lowered at
  // most once per edge and only raised again at a later edge, so no two
  // nonblocking writes to in_valid ever share a time step.
  task automatic sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offers one element and returns at the edge where it is accepted. Valid is
  // left high so a following element can go out back to back.
  task automatic send_element(logic signed [WORD_W-1:0] word, logic closes);
    sender_gap();
    in_valid <= 1'b1;
    value    <= word;
    last     <= closes;
    do @(posedge clk); while (in_stall);
    board.note_element(word, closes);
    elements_sent++;
  endtask

  // Holds the sender until every expected result has come out of the block.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
  endtask

  // Random content with a bias toward extremes and small values, the latter
  // giving plenty of equal keys.
  function automatic logic signed [WORD_W-1:0] pick_word();
    int mode;
    mode = $urandom_range(99);
    if (mode < 50) return $urandom;
    if (mode < 70) return $signed($urandom_range(8)) - 4;
    if (mode < 80) begin
      case ($urandom_range(3))
        0:       return {1'b1, {(WORD_W-1){1'b0}}};
        1:       return {1'b0, {(WORD_W-1){1'b1}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    return $signed($urandom_range(1000)) - 500;
  endfunction

  // Batch sizes: mostly small to keep the run short, a few near or past the
  // capacity so that full stores and dropped elements show up.
  function automatic int pick_batch_size();
    int mode;
    mode = $urandom_range(99);
    if (mode < 75) return $urandom_range(10, 1);
    if (mode < 90) return $urandom_range(40, 11);
    if (mode < 97) return $urandom_range(CAPACITY, 41);
    return $urandom_range(CAPACITY + 8, CAPACITY + 1);
  endfunction

  task automatic send_random_batch(int size);
    for (int idx = 0; idx < size; idx++) send_element(pick_word(), idx == size - 1);
  endtask

  // Short directed list: single-element batches at both extremes, a pair of
  // extremes, mixed signs around zero, repeated keys, a reversed run and
  // alternating bit patterns.
  localparam int DIRECTED_N = 22;
  localparam logic signed [WORD_W-1:0] DIRECTED_WORDS [DIRECTED_N] = '{
    32'sh8000_0000,
    32'sh7FFF_FFFF,
    32'sh7FFF_FFFF, 32'sh8000_0000,
    32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF,
    32'sh0000_0007, -32'sh0000_0007, 32'sh0000_0007, 32'sh0000_0007, -32'sh0000_0007,
    32'sh0000_0000,
    32'sh0000_0005, 32'sh0000_0004, 32'sh0000_0003, 32'sh0000_0002, 32'sh0000_0001,
    32'shAAAA_AAAA, 32'sh5555_5555
  };
  localparam bit DIRECTED_LAST [DIRECTED_N] = '{
    1'b1,
    1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1
  };

  // Reset is held high from time zero and then released for good.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Main stimulus and the final verdict.
  initial begin
    int random_sent;
    int size;
    int phase;
    random_sent = 0;
    phase       = 0;
    @(negedge rst);
    @(posedge clk);

    for (int idx = 0; idx < DIRECTED_N; idx++)
      send_element(DIRECTED_WORDS[idx], DIRECTED_LAST[idx]);

    // A batch that exactly fills the store, then one whose closing element
    // arrives on a full store and is itself dropped.
    send_random_batch(CAPACITY);
    send_random_batch(CAPACITY + 1);
    random_sent = 2 * CAPACITY + 1;

    while (random_sent < RANDOM_ITEMS) begin
      // Phase changes fall on batch boundaries, and the sender lets the
      // block drain completely before the idle rates change.
      if (phase == 0 && random_sent >= 130) begin
        wait_for_drain();
        phase         = 1;
        send_idle_pct = 50;
        recv_idle_pct = 6;
      end else if (phase == 1 && random_sent >= 265) begin
        wait_for_drain();
        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      size = pick_batch_size();
      send_random_batch(size);
      random_sent += size;
    end

    in_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    // Quiet cycles at the end so that any stray result still gets caught.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.error_count == 0 && board.pending_count() == 0) begin
      $display("heap_sorter_top test passed");
    end else begin
      $display("heap_sorter_top test failed");
    end
    $finish;
  end

  // Receiver side: random stall per cycle, plus one long hold-off that starts
  // when the first result of the full batch reaches the output. During the
  // hold the output register stays full, the block cannot finish its batch
  // and the sender ends up stalled.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && elements_sent >= 40 && out_valid) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Every accepted output transaction is checked against the oldest
  // expectation. Signals are read at the edge, before any update it causes.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(sorted_value, final_res, overflow);
  end

  // Hard limit on the simulation time.
  initial begin
    #5_000_000;
    $display("heap_sorter_top test failed");
    $finish;
  end

endmodule

@@ heap_sorter_top.f @@
rtl/hs_pkg.sv
rtl/hs_ram.sv
rtl/hs_dp.sv
rtl/hs_ctrl.sv
rtl/heap_sorter_top.sv
tb/tb_heap_sorter_top.sv
